FILE: hw/rtl/grouped_bitmap_block_allocator_top_macros.svh
// Assertion macros for the block allocator.
// Each macro checks an implication on the rising edge of i_clk,
// held off while i_rst_n is low.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GBBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbba assertion failed");
`define GBBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbba assertion failed");
`else
`define GBBA_ASSERT_IMP(lbl, ante, cons)
`define GBBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/gbba_pkg.sv
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared constants, codes and types of the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
package gbba_pkg;

    localparam int NUM_GROUPS       = 16;
    localparam int GROUP_SIZE       = 1024;
    localparam int MAX_ALLOC        = 16;
    localparam int WORD_BITS        = 32;
    localparam int WORDS_PER_GROUP  = GROUP_SIZE / WORD_BITS;

    localparam int BLK_W   = 14;
    localparam int OFF_W   = $clog2(GROUP_SIZE);
    localparam int GRP_W   = $clog2(NUM_GROUPS);
    localparam int WIDX_W  = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int CNT_W   = 5;
    localparam int RESV_W  = 5;
    localparam int CFG_W   = 5;
    localparam int GCNT_W  = 11;
    localparam int TOTAL_W = 15;
    localparam int ADDR_W  = GRP_W + WIDX_W;
    localparam int MEM_DEPTH = NUM_GROUPS * WORDS_PER_GROUP;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W     = $clog2(CMD_FIFO_DEPTH);

    localparam logic [GCNT_W-1:0]  GROUP_MAX = GCNT_W'(GROUP_SIZE);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(NUM_GROUPS * GROUP_SIZE);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_GROUPS = 1'b0,
        CFG_RESV   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NOSPACE      = 2'd1,
        STAT_INVALID      = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_BAD
    } t_cmd_kind;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_GSEL,
        BS_RD,
        BS_SCAN,
        BS_NOSPACE,
        BS_BAD,
        BS_FREE_RD,
        BS_FREE_CHK
    } t_bstate;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [BLK_W-1:0]   target;
        logic [CNT_W-1:0]   want;
        logic               hint_ok;
    } t_cmd;

    typedef struct packed {
        logic [GRP_W:0]     act;
        logic [RESV_W-1:0]  resv;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_sts;

endpackage

FILE: hw/rtl/gbba_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gbba_cmd_fifo
// Short command queue between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
module gbba_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbba_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output gbba_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import gbba_pkg::*;

    t_cmd                  r_mem [CMD_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_cmd   = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (FIFO_PTR_W+1)'(CMD_FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/gbba_front.sv
// ----------------------------------------------------------------------------
// gbba_front
// Accepts input beats and classifies them into queued commands.
// ----------------------------------------------------------------------------
module gbba_front (
    input  logic                       i_valid,
    input  logic                       i_opcode,
    input  logic [gbba_pkg::BLK_W-1:0] i_target_block,
    input  logic [gbba_pkg::CNT_W-1:0] i_request_count,
    input  gbba_pkg::t_cfg             i_cfg,
    input  logic                       i_hold,
    output logic                       o_stall,
    output logic                       o_push,
    output gbba_pkg::t_cmd             o_cmd
);
    import gbba_pkg::*;

    logic [GRP_W:0]     grp;
    logic [OFF_W-1:0]   off;
    logic [CNT_W-1:0]   want;
    logic               is_free;
    logic               bad_free;

    always_comb begin
        grp      = {1'b0, i_target_block[BLK_W-1:OFF_W]};
        off      = i_target_block[OFF_W-1:0];
        want     = (i_request_count > CNT_W'(MAX_ALLOC)) ? CNT_W'(MAX_ALLOC) : i_request_count;
        is_free  = (i_opcode == OP_FREE);
        bad_free = (i_target_block == '0) || (grp >= i_cfg.act)
                || (off < OFF_W'(i_cfg.resv));

        o_cmd.target  = i_target_block;
        o_cmd.want    = want;
        o_cmd.hint_ok = (grp < i_cfg.act);
        if (!is_free) begin
            o_cmd.kind = CMD_ALLOC;
        end else if (bad_free) begin
            o_cmd.kind = CMD_BAD;
        end else begin
            o_cmd.kind = CMD_FREE;
        end

        o_stall = i_hold;
        // An allocation of zero blocks is taken and produces nothing.
        o_push  = i_valid && !i_hold && (is_free || (want != '0));
    end

endmodule

FILE: hw/rtl/gbba_back.sv
// ----------------------------------------------------------------------------
// gbba_back
// Sequencer over the bitmap memory: clearing pass, group scan, frees and
// the output register.
// ----------------------------------------------------------------------------
`include "grouped_bitmap_block_allocator_top_macros.svh"

module gbba_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gbba_pkg::t_cfg               i_cfg,
    input  logic                         i_init,
    input  logic                         i_cmd_empty,
    input  gbba_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output gbba_pkg::t_back_sts          o_sts,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [gbba_pkg::BLK_W-1:0]   o_granted_block,
    output logic [1:0]                   o_status,
    output logic                         o_last,
    output logic [gbba_pkg::TOTAL_W-1:0] o_free_remaining
);
    import gbba_pkg::*;

    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_bstate              r_state, n_state;
    t_cmd                 r_cmd;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic [GRP_W:0]       r_gcnt, n_gcnt;
    logic                 r_phase, n_phase;
    logic [WIDX_W-1:0]    r_widx, n_widx;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_first, n_first;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [GCNT_W-1:0]    r_gfree [NUM_GROUPS];
    logic [TOTAL_W-1:0]   r_total, n_total;

    logic                 r_out_valid;
    logic [BLK_W-1:0]     r_out_blk;
    t_status              r_out_stat;
    logic                 r_out_last;
    logic [TOTAL_W-1:0]   r_out_total;

    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 emit, e_last, cnt_dec, cnt_inc;
    logic [BLK_W-1:0]     e_blk;
    t_status              e_stat;

    logic [GRP_W-1:0]     cur_grp, hint_grp, free_grp, upd_grp;
    logic [WORD_BITS-1:0] cur_word, resmask, avail, low;
    logic [BIT_W-1:0]     bit_idx;
    logic                 out_free, free_bit;
    logic [GCNT_W-1:0]    per_group;

    always_comb begin
        hint_grp  = r_cmd.target[BLK_W-1:OFF_W];
        free_grp  = hint_grp;
        cur_grp   = r_phase ? hint_grp : r_gcnt[GRP_W-1:0];
        cur_word  = r_first ? r_rdata : r_word;
        resmask   = (r_widx == '0) ? ((WORD_BITS'(1) << i_cfg.resv) - WORD_BITS'(1)) : '0;
        avail     = ~cur_word & ~resmask;
        low       = avail & (~avail + WORD_BITS'(1));
        bit_idx   = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low[i]) begin
                bit_idx = bit_idx | BIT_W'(i);
            end
        end
        free_bit  = r_rdata[r_cmd.target[BIT_W-1:0]];
        out_free  = !r_out_valid || !i_stall;
        per_group = GROUP_MAX - GCNT_W'(i_cfg.resv);
    end

    // Next state and strobes.
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_gcnt    = r_gcnt;
        n_phase   = r_phase;
        n_widx    = r_widx;
        n_word    = r_word;
        n_first   = r_first;
        n_n       = r_n;
        mem_we    = 1'b0;
        mem_waddr = {cur_grp, r_widx};
        mem_wdata = cur_word | low;
        mem_re    = 1'b0;
        mem_raddr = {cur_grp, r_widx};
        emit      = 1'b0;
        e_blk     = r_cmd.target;
        e_stat    = STAT_OK;
        e_last    = 1'b1;
        cnt_dec   = 1'b0;
        cnt_inc   = 1'b0;
        o_pop     = 1'b0;

        case (r_state)
            BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    o_pop   = 1'b1;
                    n_gcnt  = '0;
                    n_phase = i_cmd.hint_ok;
                    n_n     = '0;
                    case (i_cmd.kind)
                        CMD_ALLOC: n_state = BS_GSEL;
                        CMD_FREE:  n_state = BS_FREE_RD;
                        default:   n_state = BS_BAD;
                    endcase
                end
            end
            BS_GSEL: begin
                if (!r_phase && (r_gcnt >= i_cfg.act)) begin
                    n_state = BS_NOSPACE;
                end else if (!r_phase && r_cmd.hint_ok && (r_gcnt[GRP_W-1:0] == hint_grp)) begin
                    n_gcnt = r_gcnt + (GRP_W+1)'(1);
                end else if (r_gfree[cur_grp] == '0) begin
                    if (r_phase) begin
                        n_phase = 1'b0;
                    end else begin
                        n_gcnt = r_gcnt + (GRP_W+1)'(1);
                    end
                end else begin
                    n_widx  = '0;
                    n_state = BS_RD;
                end
            end
            BS_RD: begin
                mem_re  = 1'b1;
                n_first = 1'b1;
                n_state = BS_SCAN;
            end
            BS_SCAN: begin
                if (avail == '0) begin
                    if (r_widx == WIDX_W'(WORDS_PER_GROUP - 1)) begin
                        if (r_phase) begin
                            n_phase = 1'b0;
                        end else begin
                            n_gcnt = r_gcnt + (GRP_W+1)'(1);
                        end
                        n_state = BS_GSEL;
                    end else begin
                        n_widx  = r_widx + WIDX_W'(1);
                        n_state = BS_RD;
                    end
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_blk   = {cur_grp, r_widx, bit_idx};
                    e_stat  = STAT_OK;
                    e_last  = ((r_n + CNT_W'(1)) == r_cmd.want);
                    mem_we  = 1'b1;
                    n_word  = cur_word | low;
                    n_first = 1'b0;
                    cnt_dec = 1'b1;
                    n_n     = r_n + CNT_W'(1);
                    if (e_last) begin
                        n_state = BS_IDLE;
                    end
                end
            end
            BS_NOSPACE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_blk   = '0;
                    e_stat  = STAT_NOSPACE;
                    n_state = BS_IDLE;
                end
            end
            BS_BAD: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_stat  = STAT_INVALID;
                    n_state = BS_IDLE;
                end
            end
            BS_FREE_RD: begin
                mem_re    = 1'b1;
                mem_raddr = {free_grp, r_cmd.target[OFF_W-1:BIT_W]};
                n_state   = BS_FREE_CHK;
            end
            BS_FREE_CHK: begin
                mem_waddr = {free_grp, r_cmd.target[OFF_W-1:BIT_W]};
                mem_wdata = r_rdata & ~(WORD_BITS'(1) << r_cmd.target[BIT_W-1:0]);
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = BS_IDLE;
                    if (!free_bit) begin
                        e_stat = STAT_ALREADY_FREE;
                    end else begin
                        e_stat  = STAT_OK;
                        mem_we  = 1'b1;
                        cnt_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        upd_grp = cnt_inc ? free_grp : cur_grp;
        n_total = r_total;
        if (cnt_dec && (r_total != '0)) begin
            n_total = r_total - TOTAL_W'(1);
        end else if (cnt_inc && (r_total < TOTAL_MAX)) begin
            n_total = r_total + TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_init) begin
                r_state <= BS_CLEAR;
                r_clr   <= '0;
            end else begin
                r_state <= n_state;
                r_clr   <= n_clr;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gcnt  <= n_gcnt;
        r_phase <= n_phase;
        r_widx  <= n_widx;
        r_word  <= n_word;
        r_first <= n_first;
        r_n     <= n_n;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_blk   <= e_blk;
            r_out_stat  <= e_stat;
            r_out_last  <= e_last;
            r_out_total <= n_total;
        end
    end

    // Free counts are loaded on every cycle of the clearing pass.
    always_ff @(posedge i_clk) begin
        if (r_state == BS_CLEAR) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_gfree[g] <= per_group;
            end
            r_total <= TOTAL_W'(i_cfg.act) * TOTAL_W'(per_group);
        end else begin
            r_total <= n_total;
            if (cnt_dec && (r_gfree[upd_grp] != '0)) begin
                r_gfree[upd_grp] <= r_gfree[upd_grp] - GCNT_W'(1);
            end else if (cnt_inc && (r_gfree[upd_grp] < GROUP_MAX)) begin
                r_gfree[upd_grp] <= r_gfree[upd_grp] + GCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    assign o_sts.clearing   = (r_state == BS_CLEAR);
    assign o_sts.idle       = (r_state == BS_IDLE);
    assign o_valid          = r_out_valid;
    assign o_granted_block  = r_out_blk;
    assign o_status         = r_out_stat;
    assign o_last           = r_out_last;
    assign o_free_remaining = r_out_total;

    `GBBA_ASSERT_IMP(a_emit_room, emit, !r_out_valid || !i_stall)
    `GBBA_ASSERT_NEXT(a_last_to_idle, emit && e_last && !i_init, r_state == BS_IDLE)
    `GBBA_ASSERT_IMP(a_total_cap, r_state != BS_CLEAR && r_state != BS_IDLE, r_total <= TOTAL_MAX)

endmodule

FILE: hw/rtl/grouped_bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator_top
// Block allocator over 16 groups of 1024 blocks with a used-bit bitmap per
// group, a front classifier, a command queue and a back sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  input     i_valid / o_stall    i_opcode, i_target_block, i_request_count
//  result    o_valid / i_stall    o_granted_block, o_status, o_last,
//                                 o_free_remaining
//  config    i_cfg_we             i_cfg_index, i_cfg_data
//
// An allocation reads each bitmap word it scans and then checks it, and
// grants one block at a time from a word with free bits; a run that walks
// a whole group reads all of its 32 words.
// A free reads the word, then checks it and writes it back.
// After reset and after each configuration write, a clearing pass zeroes
// all 512 words of the bitmap, one word a cycle, and no input beat is taken.
// A stalled result holds the sequencer; the queue takes beats until full.
//
// The front checks a free against the active groups and the reserved offsets
// at once, so only frees of plausible blocks read the bitmap. The back holds
// the bitmap as a 512 by 32 memory addressed by group and word, plus the
// per-group and total free counts; the total goes out with every result.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic [gbba_pkg::BLK_W-1:0]   i_target_block,
    input  logic [gbba_pkg::CNT_W-1:0]   i_request_count,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gbba_pkg::BLK_W-1:0]   o_granted_block,
    output logic [1:0]                   o_status,
    output logic                         o_last,
    output logic [gbba_pkg::TOTAL_W-1:0] o_free_remaining,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [gbba_pkg::CFG_W-1:0]   i_cfg_data
);
    import gbba_pkg::*;

    logic [CFG_W-1:0] r_groups;
    logic [CFG_W-1:0] r_resv;
    t_cfg             cfg;
    t_cmd             front_cmd, queue_cmd;
    t_back_sts        back_sts;
    logic             push, pop, q_empty, q_full, hold;

    // Configuration registers. Either write restarts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups <= CFG_W'(1);
            r_resv   <= RESV_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GROUPS: r_groups <= i_cfg_data;
                CFG_RESV:   r_resv   <= i_cfg_data;
                default:    r_groups <= r_groups;
            endcase
        end
    end

    // Zero active groups behave as one; more than exist behave as all.
    always_comb begin
        if (r_groups == '0) begin
            cfg.act = (GRP_W+1)'(1);
        end else if (r_groups > CFG_W'(NUM_GROUPS)) begin
            cfg.act = (GRP_W+1)'(NUM_GROUPS);
        end else begin
            cfg.act = (GRP_W+1)'(r_groups);
        end
        cfg.resv = r_resv;
    end

    assign hold = q_full || back_sts.clearing;

    gbba_front u_front (
        .i_valid         (i_valid),
        .i_opcode        (i_opcode),
        .i_target_block  (i_target_block),
        .i_request_count (i_request_count),
        .i_cfg           (cfg),
        .i_hold          (hold),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    gbba_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gbba_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_init           (i_cfg_we),
        .i_cmd_empty      (q_empty),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_sts            (back_sts),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_granted_block  (o_granted_block),
        .o_status         (o_status),
        .o_last           (o_last),
        .o_free_remaining (o_free_remaining)
    );

endmodule
